/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/itrt_pkg.sv */
// ----------------------------------------------------------------------------
// itrt_pkg
// Types and fixed constants of the integer to radix text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

   localparam logic [7:0]  SIGN_CHAR  = 8'h2D;
   localparam logic [7:0]  ZERO_CHAR  = 8'h30;
   localparam logic [4:0]  MIN_RADIX  = 5'd2;
   localparam logic [4:0]  MAX_RADIX  = 5'd16;
   localparam logic [4:0]  RESET_RADIX = 5'd10;
   localparam logic [63:0] RESET_CHARS_LOW  = 64'd3978425819141910832;
   localparam logic [63:0] RESET_CHARS_HIGH = 64'd5063528411713059128;

   // quotient bits resolved per divider cycle
   localparam int DIV_BITS_PER_CYCLE = 8;

   typedef enum logic [1:0] {
      CSR_RADIX      = 2'd0,
      CSR_CHARS_LOW  = 2'd1,
      CSR_CHARS_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic is_negative;
      logic is_zero;
   } item_flags_type;

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_DIV   = 4'b0010,
      B_PRIME = 4'b0100,
      B_EMIT  = 4'b1000
   } back_state_type;

endpackage

/* sv/itrt_front.sv */
// ----------------------------------------------------------------------------
// itrt_front
// Accepts a number, splits it into sign and magnitude and flags zero.
// ----------------------------------------------------------------------------
module itrt_front #(
   parameter int WORD_BITS = 32
) (
   input  logic                        start,
   input  logic signed [WORD_BITS-1:0] req_number,
   input  logic                        queue_full,
   output logic                        busy,
   output logic                        push,
   output logic [WORD_BITS-1:0]        push_mag,
   output itrt_pkg::item_flags_type    push_flags
);

   logic [WORD_BITS-1:0] raw;

   assign raw  = req_number;
   assign busy = queue_full;
   assign push = start && !queue_full;

   // two's complement negate; the most negative value maps onto itself,
   // which read unsigned is the exact magnitude
   assign push_mag = raw[WORD_BITS-1] ? (~raw + WORD_BITS'(1)) : raw;

   assign push_flags.is_negative = raw[WORD_BITS-1];
   assign push_flags.is_zero     = (raw == '0);

endmodule

/* sv/itrt_queue.sv */
// ----------------------------------------------------------------------------
// itrt_queue
// Two-entry queue between the front and the conversion engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itrt_queue #(
   parameter int DATA_W = 34
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              empty,
   output logic              full
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign empty     = (count_ff == 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !full || pop)
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, !empty)

endmodule

/* sv/itrt_back.sv */
// ----------------------------------------------------------------------------
// itrt_back
// Conversion engine: divides the magnitude by the radix digit by digit,
// stores the digits, then plays them out most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itrt_back #(
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  logic [WORD_BITS-1:0]     head_mag,
   input  itrt_pkg::item_flags_type head_flags,
   output logic                     pop,
   input  logic [4:0]               radix,
   input  logic [63:0]              digit_chars_low,
   input  logic [63:0]              digit_chars_high,
   output logic                     rsp_strobe,
   output logic [7:0]               rsp_text_char,
   output logic                     rsp_last_char
);

   localparam int CHUNK  = itrt_pkg::DIV_BITS_PER_CYCLE;
   localparam int STEPS  = (WORD_BITS + CHUNK - 1) / CHUNK;
   localparam int PAD_W  = STEPS * CHUNK;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int IDX_W  = $clog2(WORD_BITS);

   itrt_pkg::back_state_type state_ff, state_in;

   logic [PAD_W-1:0]  div_ff, div_in;
   logic [3:0]        pr_ff, pr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              neg_ff, neg_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]        rsp_text_char_ff, rsp_text_char_in;
   logic              rsp_last_char_ff, rsp_last_char_in;

   logic [3:0]        digit_store [WORD_BITS];
   logic [3:0]        rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;

   logic [4:0]        eff_radix;
   logic [PAD_W-1:0]  div_chunk;
   logic [3:0]        pr_chunk;
   logic [127:0]      alphabet;

   assign alphabet = {digit_chars_high, digit_chars_low};

   always_comb begin
      eff_radix = radix;
      if (radix < itrt_pkg::MIN_RADIX) begin
         eff_radix = itrt_pkg::MIN_RADIX;
      end else if (radix > itrt_pkg::MAX_RADIX) begin
         eff_radix = itrt_pkg::MAX_RADIX;
      end
   end

   // restoring division, CHUNK quotient bits per cycle; partial remainder
   // stays below the radix so every step works on five bits
   always_comb begin
      logic [4:0]       trial;
      logic [3:0]       pr;
      logic [PAD_W-1:0] d;
      pr = pr_ff;
      d  = div_ff;
      for (int j = 0; j < CHUNK; j++) begin
         trial = {pr, d[PAD_W-1]};
         d     = {d[PAD_W-2:0], 1'b0};
         if (trial >= eff_radix) begin
            trial = trial - eff_radix;
            d[0]  = 1'b1;
         end
         pr = trial[3:0];
      end
      div_chunk = d;
      pr_chunk  = pr;
   end

   assign rd_addr = (state_ff == itrt_pkg::B_EMIT) ? (idx_ff - IDX_W'(1)) : idx_ff;

   always_comb begin
      state_in         = state_ff;
      div_in           = div_ff;
      pr_in            = pr_ff;
      step_in          = step_ff;
      cnt_in           = cnt_ff;
      idx_in           = idx_ff;
      neg_in           = neg_ff;
      rsp_strobe_in    = 1'b0;
      rsp_text_char_in = rsp_text_char_ff;
      rsp_last_char_in = rsp_last_char_ff;
      pop              = 1'b0;
      wr_en            = 1'b0;
      case (state_ff)
         itrt_pkg::B_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head_flags.is_zero) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_text_char_in = itrt_pkg::ZERO_CHAR;
                  rsp_last_char_in = 1'b1;
               end else begin
                  state_in = itrt_pkg::B_DIV;
                  div_in   = PAD_W'(head_mag);
                  pr_in    = 4'd0;
                  step_in  = '0;
                  cnt_in   = '0;
                  neg_in   = head_flags.is_negative;
               end
            end
         end
         itrt_pkg::B_DIV: begin
            div_in  = div_chunk;
            pr_in   = pr_chunk;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               wr_en   = 1'b1;
               step_in = '0;
               pr_in   = 4'd0;
               if (div_chunk != '0) begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end else begin
                  // last digit written: send the sign while the first read primes
                  idx_in   = cnt_ff;
                  state_in = itrt_pkg::B_PRIME;
                  if (neg_ff) begin
                     rsp_strobe_in    = 1'b1;
                     rsp_text_char_in = itrt_pkg::SIGN_CHAR;
                     rsp_last_char_in = 1'b0;
                  end
               end
            end
         end
         itrt_pkg::B_PRIME: begin
            state_in = itrt_pkg::B_EMIT;
         end
         itrt_pkg::B_EMIT: begin
            rsp_strobe_in    = 1'b1;
            rsp_text_char_in = alphabet[{rd_data_ff, 3'b000} +: 8];
            rsp_last_char_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = itrt_pkg::B_IDLE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = itrt_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itrt_pkg::B_IDLE;
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
         neg_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cnt_ff        <= cnt_in;
         neg_ff        <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff           <= div_in;
      pr_ff            <= pr_in;
      step_ff          <= step_in;
      idx_ff           <= idx_in;
      rsp_text_char_ff <= rsp_text_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store[cnt_ff] <= pr_chunk;
      end
      rd_data_ff <= digit_store[rd_addr];
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_text_char = rsp_text_char_ff;
   assign rsp_last_char = rsp_last_char_ff;

   `ASSERT_NEXT(a_emit_strobes, clock, reset, state_ff == itrt_pkg::B_EMIT, rsp_strobe)
   `ASSERT_IMPLIES(a_pop_only_idle, clock, reset, pop, state_ff == itrt_pkg::B_IDLE)

endmodule

/* sv/int_to_radix_text_top.sv */
// ----------------------------------------------------------------------------
// int_to_radix_text_top
// Converts a signed integer into its text form in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_number and raise start; the number transfers at a rising
//   edge where start is high and busy is low. busy rises only when the
//   two-entry queue in front of the conversion engine is full.
//   Output: characters on rsp_text_char with rsp_strobe high, digits one per
//   cycle, most significant first, a leading '-' for negative numbers, and
//   rsp_last_char high on the final character. The receiver cannot stall:
//   each character is valid for exactly one cycle.
//   Timing: a zero goes into the queue, is popped by the idle engine and its
//   '0' is registered out. Otherwise the engine runs the divider for each
//   digit (8 quotient bits per cycle) and writes it to the digit store;
//   after the last digit it sends any sign, primes the digit store read,
//   then plays the digits out one per cycle. The engine takes the next
//   number from the queue only once it is back in idle.
//   Configuration: csr_write_enable writes register csr_index (0 radix,
//   1 low alphabet bytes, 2 high alphabet bytes); write only while idle.
//   Reset: synchronous; restores radix 10 and the "0123456789ABCDEF"
//   alphabet and empties the queue.
// ----------------------------------------------------------------------------
module int_to_radix_text_top #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [WORD_BITS-1:0] req_number,
   output logic                        rsp_strobe,
   output logic [7:0]                  rsp_text_char,
   output logic                        rsp_last_char,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [63:0]                 csr_write_data
);

   localparam int FLAGS_W = $bits(itrt_pkg::item_flags_type);
   localparam int ITEM_W  = FLAGS_W + WORD_BITS;

   // configuration registers
   logic [4:0]  radix_ff, radix_in;
   logic [63:0] chars_low_ff, chars_low_in;
   logic [63:0] chars_high_ff, chars_high_in;

   // front to queue
   logic                     push;
   logic [WORD_BITS-1:0]     push_mag;
   itrt_pkg::item_flags_type push_flags;

   // queue to back
   logic                     queue_full;
   logic                     queue_empty;
   logic                     pop;
   logic [ITEM_W-1:0]        head_data;
   logic [WORD_BITS-1:0]     head_mag;
   itrt_pkg::item_flags_type head_flags;

   // decode a register write; unknown indexes drop silently
   always_comb begin
      radix_in      = radix_ff;
      chars_low_in  = chars_low_ff;
      chars_high_in = chars_high_ff;
      if (csr_write_enable) begin
         case (itrt_pkg::csr_index_type'(csr_index))
            itrt_pkg::CSR_RADIX:      radix_in      = csr_write_data[4:0];
            itrt_pkg::CSR_CHARS_LOW:  chars_low_in  = csr_write_data;
            itrt_pkg::CSR_CHARS_HIGH: chars_high_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= itrt_pkg::RESET_RADIX;
         chars_low_ff  <= itrt_pkg::RESET_CHARS_LOW;
         chars_high_ff <= itrt_pkg::RESET_CHARS_HIGH;
      end else begin
         radix_ff      <= radix_in;
         chars_low_ff  <= chars_low_in;
         chars_high_ff <= chars_high_in;
      end
   end

   // front: take the number, split sign from magnitude
   itrt_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .start      (start),
      .req_number (req_number),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .push_mag   (push_mag),
      .push_flags (push_flags)
   );

   // queue: lets the front keep taking numbers while the engine works
   itrt_queue #(
      .DATA_W (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_flags, push_mag}),
      .pop       (pop),
      .head_data (head_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   assign head_mag   = head_data[WORD_BITS-1:0];
   assign head_flags = head_data[ITEM_W-1:WORD_BITS];

   // back: divide, store digits, play them out
   itrt_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .head_mag         (head_mag),
      .head_flags       (head_flags),
      .pop              (pop),
      .radix            (radix_ff),
      .digit_chars_low  (chars_low_ff),
      .digit_chars_high (chars_high_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char)
   );

endmodule

/* sim/itrt_text_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itrt_text_checker
// Watches the number and character channels of the radix text converter,
// keeps its own copy of the registers, predicts each character and compares.
// ----------------------------------------------------------------------------
module itrt_text_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_number,
   input  logic               rsp_strobe,
   input  logic [7:0]         rsp_text_char,
   input  logic               rsp_last_char,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_write_data,
   output int                 error_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
   } text_char_entry_type;

   logic [4:0]          radix_setting;
   logic [63:0]         chars_low;
   logic [63:0]         chars_high;
   text_char_entry_type expected_chars[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t checker: %s", $time, what);
      error_count = error_count + 1;
   endtask

   // Queue the characters one number turns into under the current settings.
   function automatic void predict_text(input logic [31:0] value);
      logic [4:0]          base;
      logic [31:0]         magnitude;
      logic [127:0]        alphabet;
      logic [3:0]          digits[$];
      text_char_entry_type entry;
      base = radix_setting;
      if (base < itrt_pkg::MIN_RADIX) begin
         base = itrt_pkg::MIN_RADIX;
      end else if (base > itrt_pkg::MAX_RADIX) begin
         base = itrt_pkg::MAX_RADIX;
      end
      alphabet  = {chars_high, chars_low};
      magnitude = value[31] ? (~value + 32'd1) : value;
      if (magnitude == 32'd0) begin
         entry.text_char = itrt_pkg::ZERO_CHAR;
         entry.last_char = 1'b1;
         expected_chars.push_back(entry);
         return;
      end
      while (magnitude != 32'd0) begin
         digits.push_front(4'(magnitude % {27'd0, base}));
         magnitude = magnitude / {27'd0, base};
      end
      if (value[31]) begin
         entry.text_char = itrt_pkg::SIGN_CHAR;
         entry.last_char = 1'b0;
         expected_chars.push_back(entry);
      end
      foreach (digits[i]) begin
         entry.text_char = alphabet[digits[i]*8 +: 8];
         entry.last_char = (i == digits.size() - 1);
         expected_chars.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      text_char_entry_type oldest;
      if (reset) begin
         radix_setting = itrt_pkg::RESET_RADIX;
         chars_low     = itrt_pkg::RESET_CHARS_LOW;
         chars_high    = itrt_pkg::RESET_CHARS_HIGH;
         expected_chars.delete();
      end else begin
         if (csr_write_enable) begin
            case (itrt_pkg::csr_index_type'(csr_index))
               itrt_pkg::CSR_RADIX:      radix_setting = csr_write_data[4:0];
               itrt_pkg::CSR_CHARS_LOW:  chars_low     = csr_write_data;
               itrt_pkg::CSR_CHARS_HIGH: chars_high    = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character %h with nothing pending", rsp_text_char));
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp_text_char !== oldest.text_char)
                  report_mismatch($sformatf("text_char %h, expected %h",
                                            rsp_text_char, oldest.text_char));
               if (rsp_last_char !== oldest.last_char)
                  report_mismatch($sformatf("last_char %b, expected %b on char %h",
                                            rsp_last_char, oldest.last_char,
                                            oldest.text_char));
            end
         end
         if (start && !busy) begin
            predict_text(req_number);
         end
      end
      pending_count <= expected_chars.size();
   end

endmodule

/* sim/int_to_radix_text_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int_to_radix_text_top_test
// Drives numbers and register settings into the radix text converter; a
// checker beside the block predicts every character and counts mismatches.
// ----------------------------------------------------------------------------
module int_to_radix_text_top_test;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int TAIL_CYCLES   = 64;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 25;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_number;
   logic               rsp_strobe;
   logic [7:0]         rsp_text_char;
   logic               rsp_last_char;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [63:0]        csr_write_data;
   int                 error_count;
   int                 pending_count;

   // radix the block really uses, kept here only to shape the stimulus
   int                 active_radix;

   int_to_radix_text_top #(.WORD_BITS(32)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number       (req_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   itrt_text_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_number       (req_number),
      .rsp_strobe       (rsp_strobe),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Hard stop: covers a hung handshake or characters that never come.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("int_to_radix_text_top_test: errors");
      $finish;
   end

   // Offer one number and hold it until the block takes it. Optionally
   // drop start for a short burst first. Entered and left at a falling edge;
   // start stays high on exit so back-to-back transfers need no toggle.
   task automatic send_number(input logic [31:0] value, input bit allow_idle);
      if (allow_idle && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      start      <= 1'b1;
      req_number <= value;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   // Drop start and wait until every predicted character has come out;
   // with no pending characters the block has nothing left in flight.
   task automatic drain;
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Write all three registers back to back while the block is idle. Write
   // enable stays high across the writes and drops after the last one.
   task automatic configure(input logic [4:0] radix_bits, input logic [63:0] low_chars,
                            input logic [63:0] high_chars);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= itrt_pkg::CSR_RADIX;
      // upper data bits are don't-care for the radix register
      csr_write_data   <= {$urandom, 27'($urandom), radix_bits};
      @(negedge clock);
      csr_index        <= itrt_pkg::CSR_CHARS_LOW;
      csr_write_data   <= low_chars;
      @(negedge clock);
      csr_index        <= itrt_pkg::CSR_CHARS_HIGH;
      csr_write_data   <= high_chars;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (radix_bits < itrt_pkg::MIN_RADIX) active_radix = itrt_pkg::MIN_RADIX;
      else if (radix_bits > itrt_pkg::MAX_RADIX) active_radix = itrt_pkg::MAX_RADIX;
      else active_radix = radix_bits;
   endtask

   function automatic logic [63:0] random_chars();
      return {$urandom, $urandom};
   endfunction

   // Pick a number: short ones most often, so the run stays quick, plus
   // full-range values, the sign edges and numbers around powers of the radix.
   function automatic logic [31:0] pick_number();
      longint power;
      int     steps;
      int     kind;
      logic [31:0] value;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         value = $urandom_range(0, 999);
         if ($urandom_range(0, 1)) value = -value;
      end else if (kind < 65) begin
         value = $urandom;
      end else if (kind < 80) begin
         case ($urandom_range(0, 6))
            0: value = 32'h0000_0000;
            1: value = 32'h0000_0001;
            2: value = 32'hFFFF_FFFF;
            3: value = 32'h7FFF_FFFF;
            4: value = 32'h8000_0000;
            5: value = 32'h8000_0001;
            default: value = 32'h7FFF_FFFE;
         endcase
      end else begin
         power = 1;
         steps = $urandom_range(1, 31);
         while (steps > 0 && power * active_radix <= 64'sd2147483647) begin
            power = power * active_radix;
            steps--;
         end
         power = power + $urandom_range(0, 2) - 1;
         value = power[31:0];
         if ($urandom_range(0, 1)) value = -value;
      end
      return value;
   endfunction

   initial begin
      logic [4:0] radix_bits;
      logic [63:0] low_chars;
      logic [63:0] high_chars;
      bit allow_idle;

      // every input known from time zero; reset starts high
      reset            = 1'b1;
      start            = 1'b0;
      req_number       = '0;
      csr_write_enable = 1'b0;
      csr_index        = itrt_pkg::CSR_RADIX;
      csr_write_data   = '0;
      active_radix     = itrt_pkg::RESET_RADIX;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings first, decimal with the default alphabet.
      send_number(32'd0, 1'b1);
      send_number(32'd1, 1'b1);
      send_number(32'hFFFF_FFFF, 1'b1);
      send_number(32'd9, 1'b1);
      send_number(-32'sd10, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b0);
      send_number(32'h8000_0000, 1'b1);
      send_number(32'd123456789, 1'b1);

      // Binary with extreme alphabets: the most negative value gives the
      // longest text, a sign and 32 digits.
      configure(5'd2, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_number(32'h8000_0000, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b1);
      send_number(32'd5, 1'b1);

      // Radix field below range acts as binary; zero must still be ASCII
      // '0' whatever the alphabet holds for digit zero.
      configure(5'd0, 64'h6162_6364_6566_6768, random_chars());
      send_number(32'd0, 1'b1);
      send_number(32'd6, 1'b1);

      // Radix field at its top value acts as hexadecimal.
      configure(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
      send_number(32'h8000_0000, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b0);
      send_number(32'd255, 1'b1);
      send_number(-32'sd4096, 1'b1);

      configure(5'd1, itrt_pkg::RESET_CHARS_LOW, itrt_pkg::RESET_CHARS_HIGH);
      send_number(32'd3, 1'b1);

      // just above the top radix, with a repeated character in the alphabet
      configure(5'd17, 64'h3737_3737_3737_3737, itrt_pkg::RESET_CHARS_HIGH);
      send_number(32'd16, 1'b1);
      send_number(-32'sd17, 1'b1);

      configure(itrt_pkg::MAX_RADIX, itrt_pkg::RESET_CHARS_LOW, itrt_pkg::RESET_CHARS_HIGH);
      send_number(32'hDEAD_BEEF, 1'b1);

      // Random phases, each with fresh settings; the last phases run
      // without idle bursts so transfers go back to back.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       radix_bits = itrt_pkg::MIN_RADIX;
            1:       radix_bits = itrt_pkg::MAX_RADIX;
            2:       radix_bits = 5'($urandom_range(0, 31));
            default: radix_bits = 5'($urandom_range(2, 16));
         endcase
         if ($urandom_range(0, 3) == 0) begin
            low_chars  = itrt_pkg::RESET_CHARS_LOW;
            high_chars = itrt_pkg::RESET_CHARS_HIGH;
         end else begin
            low_chars  = random_chars();
            high_chars = random_chars();
         end
         configure(radix_bits, low_chars, high_chars);
         allow_idle = (phase < RANDOM_PHASES - 2);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            send_number(pick_number(), allow_idle);
         end
      end

      // Wait out every character, then a quiet tail to catch strays.
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("int_to_radix_text_top_test: clean");
      end else begin
         $display("int_to_radix_text_top_test: errors");
      end
      $finish;
   end

endmodule

/* int_to_radix_text_top.f */
+incdir+sv
sv/itrt_pkg.sv
sv/itrt_front.sv
sv/itrt_queue.sv
sv/itrt_back.sv
sv/int_to_radix_text_top.sv
sim/itrt_text_checker.sv
sim/int_to_radix_text_top_test.sv
